[src/oidst_pkg.sv]
// Shared constants and types for the ordered identifier set table.
package oidst_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ID_W        = 32;
    localparam int IDX_W       = 4;
    localparam int OUT_CNT_W   = 5;
    localparam int PTR_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = CNT_W + IDX_W;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

endpackage

[src/ordered_id_set_table_unit.sv]
// Ordered identifier set table: sequencer, entry memory and result register.
//
// Usage: one command per transfer on the s_ channel (add, remove, contains,
// read at index); exactly one result per command on the m_ channel, giving
// ok, the id read (zero unless a read hits) and the count after the command.
// The block takes one command at a time: s_ready is high only while idle.
// A single compare unit walks the entry memory one slot per cycle, reading
// through one registered read port:
//   zero id, empty set   : result without a walk
//   read at index        : one registered read, then the result (direct on a miss)
//   contains / add       : walk up to MAX_ENTRIES slots
//   remove               : walk to the match, then shift each later entry
//                          down one slot per cycle, then clear the freed
//                          last slot
// The result stays on the m_ ports until the receiver takes it; while the
// receiver stalls, no new command is accepted.
// Reset (aresetn low at a clock edge) empties the set at once; slots beyond
// the count are never read, so the memory needs no clearing pass.
module ordered_id_set_table_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [oidst_pkg::ID_W-1:0]   s_node_id,
    input  logic [oidst_pkg::IDX_W-1:0]  s_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [oidst_pkg::ID_W-1:0]   m_id_out,
    output logic [oidst_pkg::OUT_CNT_W-1:0] m_entry_count
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_ZERO,
        ST_READ,
        ST_RESP
    } state_t;

    state_t                          state_reg, state_next;
    oidst_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [oidst_pkg::ID_W-1:0]      id_reg, id_next;
    logic [oidst_pkg::PTR_W-1:0]     ptr_reg, ptr_next;
    logic [oidst_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                            ok_reg, ok_next;
    logic [oidst_pkg::ID_W-1:0]      id_out_reg, id_out_next;

    logic [oidst_pkg::ID_W-1:0]      mem [oidst_pkg::MAX_ENTRIES];
    logic [oidst_pkg::ID_W-1:0]      rd_data_reg;
    logic [oidst_pkg::PTR_W-1:0]     rd_addr;
    logic                            wr_en;
    logic [oidst_pkg::PTR_W-1:0]     wr_addr;
    logic [oidst_pkg::ID_W-1:0]      wr_data;

    logic [oidst_pkg::CNT_W-1:0]     ptr_ext;
    logic [oidst_pkg::CNT_W-1:0]     ptr_p1;
    logic [oidst_pkg::CNT_W-1:0]     ptr_p2;
    logic                            not_full;
    logic                            idx_hit;

    assign ptr_ext  = oidst_pkg::CNT_W'(ptr_reg);
    assign ptr_p1   = ptr_ext + oidst_pkg::CNT_W'(1);
    assign ptr_p2   = ptr_ext + oidst_pkg::CNT_W'(2);
    assign not_full = count_reg < oidst_pkg::CNT_W'(oidst_pkg::MAX_ENTRIES);
    assign idx_hit  = (oidst_pkg::CMP_W'(s_index) < oidst_pkg::CMP_W'(count_reg)) &&
                      (oidst_pkg::CMP_W'(s_index) <
                       oidst_pkg::CMP_W'(oidst_pkg::MAX_ENTRIES));

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_RESP);
    assign m_ok          = ok_reg;
    assign m_id_out      = id_out_reg;
    assign m_entry_count = oidst_pkg::OUT_CNT_W'(count_reg);

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        id_next     = id_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        ok_next     = ok_reg;
        id_out_next = id_out_reg;
        rd_addr     = ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = rd_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = oidst_pkg::cmd_t'(s_cmd);
                    id_next     = s_node_id;
                    ptr_next    = '0;
                    ok_next     = 1'b0;
                    id_out_next = '0;
                    if (oidst_pkg::cmd_t'(s_cmd) == oidst_pkg::CMD_READ) begin
                        rd_addr = oidst_pkg::PTR_W'(s_index);
                        state_next = idx_hit ? ST_READ : ST_RESP;
                    end else if (s_node_id == '0) begin
                        state_next = ST_RESP;
                    end else if (count_reg == '0) begin
                        // empty set: only an add can succeed
                        if (oidst_pkg::cmd_t'(s_cmd) == oidst_pkg::CMD_ADD) begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = s_node_id;
                            count_next = count_reg + oidst_pkg::CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                        state_next = ST_RESP;
                    end else begin
                        rd_addr    = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_data_reg == id_reg) begin
                    if (cmd_reg == oidst_pkg::CMD_REMOVE) begin
                        ok_next = 1'b1;
                        if (ptr_p1 < count_reg) begin
                            rd_addr    = oidst_pkg::PTR_W'(ptr_p1);
                            state_next = ST_SHIFT;
                        end else begin
                            state_next = ST_ZERO;
                        end
                    end else begin
                        ok_next    = 1'b1;
                        state_next = ST_RESP;
                    end
                end else if (ptr_p1 < count_reg) begin
                    rd_addr    = oidst_pkg::PTR_W'(ptr_p1);
                    ptr_next   = oidst_pkg::PTR_W'(ptr_p1);
                end else begin
                    // not present: append on add if room is left
                    if (cmd_reg == oidst_pkg::CMD_ADD && not_full) begin
                        wr_en      = 1'b1;
                        wr_addr    = oidst_pkg::PTR_W'(count_reg);
                        wr_data    = id_reg;
                        count_next = count_reg + oidst_pkg::CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT: begin
                // move the later entry down one slot
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data_reg;
                ptr_next = oidst_pkg::PTR_W'(ptr_p1);
                if (ptr_p2 < count_reg) begin
                    rd_addr = oidst_pkg::PTR_W'(ptr_p2);
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_data    = '0;
                count_next = count_reg - oidst_pkg::CNT_W'(1);
                state_next = ST_RESP;
            end
            ST_READ: begin
                id_out_next = rd_data_reg;
                ok_next     = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        ptr_reg    <= ptr_next;
        ok_reg     <= ok_next;
        id_out_reg <= id_out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_ready_result_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= oidst_pkg::CNT_W'(oidst_pkg::MAX_ENTRIES))
        else $error("entry count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready in the cycle after a transfer");

    a_count_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + oidst_pkg::CNT_W'(1)) ||
         (count_reg == $past(count_reg) - oidst_pkg::CNT_W'(1)) ||
         ($past(count_reg) == '0 && $past(!aresetn)) || (count_reg == '0)))
        else $error("entry count jumped by more than one");

endmodule

[test/tb_ordered_id_set_table_unit.sv]
// Testbench for the ordered identifier set table: directed and random commands checked against a predictor.
module tb_ordered_id_set_table_unit;

    typedef struct {
        logic                            ok;
        logic [oidst_pkg::ID_W-1:0]      id_out;
        logic [oidst_pkg::OUT_CNT_W-1:0] entry_count;
    } set_result_t;

    class id_set_predictor;
        logic [oidst_pkg::ID_W-1:0] entries [oidst_pkg::MAX_ENTRIES];
        int              used;
        set_result_t     pending_results [$];
        int              errors;

        function new();
            foreach (entries[i]) entries[i] = '0;
            used   = 0;
            errors = 0;
        endfunction

        function int find_pos(logic [oidst_pkg::ID_W-1:0] id);
            for (int i = 0; i < used; i++) begin
                if (entries[i] == id) return i;
            end
            return -1;
        endfunction

        function void note_command(oidst_pkg::cmd_t cmd, logic [oidst_pkg::ID_W-1:0] id,
                                   logic [oidst_pkg::IDX_W-1:0] idx);
            set_result_t r;
            int          pos;
            r.ok     = 1'b0;
            r.id_out = '0;
            case (cmd)
                oidst_pkg::CMD_ADD: begin
                    if (id != '0) begin
                        if (find_pos(id) >= 0) begin
                            r.ok = 1'b1;
                        end else if (used < oidst_pkg::MAX_ENTRIES) begin
                            entries[used] = id;
                            used++;
                            r.ok = 1'b1;
                        end
                    end
                end
                oidst_pkg::CMD_REMOVE: begin
                    if (id != '0) begin
                        pos = find_pos(id);
                        if (pos >= 0) begin
                            // close the gap, keep insertion order
                            for (int i = pos; i + 1 < used; i++) entries[i] = entries[i + 1];
                            used--;
                            entries[used] = '0;
                            r.ok = 1'b1;
                        end
                    end
                end
                oidst_pkg::CMD_CONTAINS: begin
                    if (id != '0 && find_pos(id) >= 0) r.ok = 1'b1;
                end
                default: begin
                    if (int'(idx) < used) begin
                        r.id_out = entries[idx];
                        r.ok     = 1'b1;
                    end
                end
            endcase
            r.entry_count = used[oidst_pkg::OUT_CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic ok, logic [oidst_pkg::ID_W-1:0] id_out,
                                   logic [oidst_pkg::OUT_CNT_W-1:0] entry_count);
            set_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual ok %0d id %h count %0d",
                         $time, ok, id_out, entry_count);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (ok !== e.ok) begin
                $display("%0t: ok mismatch, expected %0d, actual %0d", $time, e.ok, ok);
                errors++;
            end
            if (id_out !== e.id_out) begin
                $display("%0t: id_out mismatch, expected %h, actual %h", $time, e.id_out, id_out);
                errors++;
            end
            if (entry_count !== e.entry_count) begin
                $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                         $time, e.entry_count, entry_count);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [1:0]                      s_cmd;
    logic [oidst_pkg::ID_W-1:0]      s_node_id;
    logic [oidst_pkg::IDX_W-1:0]     s_index;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_ok;
    logic [oidst_pkg::ID_W-1:0]      m_id_out;
    logic [oidst_pkg::OUT_CNT_W-1:0] m_entry_count;

    id_set_predictor set_model = new();
    bit              calm;
    logic [oidst_pkg::ID_W-1:0] id_pool [24];

    ordered_id_set_table_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_node_id     (s_node_id),
        .s_index       (s_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_id_out      (m_id_out),
        .m_entry_count (m_entry_count)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // receiver: stall at random outside the calm stretch
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else          m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) set_model.check_result(m_ok, m_id_out, m_entry_count);
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_command(oidst_pkg::cmd_t cmd, logic [oidst_pkg::ID_W-1:0] id,
                                logic [oidst_pkg::IDX_W-1:0] idx);
        while (!calm && $urandom_range(0, 99) < 17) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_node_id <= id;
        s_index   <= idx;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        set_model.note_command(cmd, id, idx);
        @(negedge aclk);
    endtask

    function automatic logic [oidst_pkg::ID_W-1:0] pick_id();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)  return '0;
        if (roll < 8)  return '1;
        if (roll < 16) return $urandom();
        if (roll < 50 && set_model.used > 0)
            return set_model.entries[$urandom_range(0, set_model.used - 1)];
        return id_pool[$urandom_range(0, 23)];
    endfunction

    task automatic run_random(int count);
        int unsigned     roll;
        int unsigned     add_pct;
        oidst_pkg::cmd_t cmd;
        for (int n = 0; n < count; n++) begin
            calm = (n >= 700 && n < 1000);
            // alternate fill-heavy and drain-heavy phases to sweep the count
            add_pct = ((n / 150) % 2 == 0) ? 55 : 15;
            roll = $urandom_range(0, 99);
            if (roll < add_pct)                 cmd = oidst_pkg::CMD_ADD;
            else if (roll < add_pct + 15)       cmd = oidst_pkg::CMD_CONTAINS;
            else if (roll < add_pct + 30)       cmd = oidst_pkg::CMD_READ;
            else                                cmd = oidst_pkg::CMD_REMOVE;
            send_command(cmd, pick_id(), $urandom_range(0, 15));
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_cmd     = oidst_pkg::CMD_ADD;
        s_node_id = '0;
        s_index   = '0;
        m_ready   = 1'b0;
        calm      = 1'b0;
        foreach (id_pool[i]) id_pool[i] = $urandom() | 32'h1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty-set corner cases
        send_command(oidst_pkg::CMD_READ, '0, 4'd0);
        send_command(oidst_pkg::CMD_READ, '0, 4'd15);
        send_command(oidst_pkg::CMD_ADD, '0, 4'd0);
        send_command(oidst_pkg::CMD_CONTAINS, '0, 4'd0);
        send_command(oidst_pkg::CMD_REMOVE, '0, 4'd0);
        send_command(oidst_pkg::CMD_REMOVE, 32'h1234_5678, 4'd0);
        send_command(oidst_pkg::CMD_ADD, '1, 4'd0);
        send_command(oidst_pkg::CMD_ADD, '1, 4'd0);
        send_command(oidst_pkg::CMD_CONTAINS, '1, 4'd0);
        // fill to capacity, then add one more
        for (int i = 1; i < oidst_pkg::MAX_ENTRIES; i++)
            send_command(oidst_pkg::CMD_ADD, 32'h1 << (i * 2), 4'd0);
        send_command(oidst_pkg::CMD_ADD, 32'h0000_0003, 4'd0);
        send_command(oidst_pkg::CMD_ADD, 32'h1 << 2, 4'd0);
        send_command(oidst_pkg::CMD_READ, '0, 4'd15);
        send_command(oidst_pkg::CMD_REMOVE, 32'h1 << 10, 4'd0);
        send_command(oidst_pkg::CMD_READ, '0, 4'd15);
        send_command(oidst_pkg::CMD_READ, '0, 4'd5);
        send_command(oidst_pkg::CMD_REMOVE, '1, 4'd0);
        send_command(oidst_pkg::CMD_CONTAINS, '1, 4'd0);
        send_command(oidst_pkg::CMD_READ, '0, 4'd0);

        run_random(1700);

        s_valid <= 1'b0;
        while (set_model.pending_results.size() != 0) @(posedge aclk);
        repeat (2 * oidst_pkg::MAX_ENTRIES + 10) @(posedge aclk);
        if (set_model.errors == 0 && set_model.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
